[hw/rtl/twg_pkg.sv]
// shared constants, register map and sine table entry function for the tone generator
package twg_pkg;

  localparam int AMP_W    = 15;
  localparam int GAIN_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 32;
  localparam int LEN_W    = 25;
  localparam int MODE_W   = 1;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;
  localparam int REG_SEL_W = 2;

  localparam logic [AMP_W-1:0]  FULL_AMP   = 15'd32760;
  localparam logic [GAIN_W-1:0] GAIN_FULL  = 16'd32768;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 25'd44100;
  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0]       Q30_ONE     = 64'd1 << 30;

  localparam logic [MODE_W-1:0] MODE_SINE   = 1'b0;
  localparam logic [MODE_W-1:0] MODE_SQUARE = 1'b1;

  // register index, byte address bits [3:2]
  localparam logic [REG_SEL_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_VOLUME     = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_WAVE_MODE  = 2'd2;
  localparam logic [REG_SEL_W-1:0] REG_LENGTH     = 2'd3;

  // quarter-wave entry: 32760*sin(i/N * pi/2), taylor series in q2.30
  function automatic logic [AMP_W-1:0] sine_entry(input int unsigned idx,
                                                  input int unsigned addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] amp;
    x  = (HALF_PI_Q30 * 64'(idx)) >> addr_bits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int k = 0; k < 6; k++) begin
      p = (x2 * t) >> 30;
      case (k)
        0:       d = p / 156;
        1:       d = p / 110;
        2:       d = p / 72;
        3:       d = p / 42;
        4:       d = p / 20;
        default: d = p / 6;
      endcase
      t = (d >= Q30_ONE) ? 64'd0 : (Q30_ONE - d);
    end
    s   = (x * t) >> 30;
    amp = (64'(FULL_AMP) * s + (Q30_ONE >> 1)) >> 30;
    if (amp > 64'(FULL_AMP)) begin
      amp = 64'(FULL_AMP);
    end
    return amp[AMP_W-1:0];
  endfunction

endpackage

[hw/rtl/twg_sine_rom.sv]
// quarter-wave sine rom with registered read port
module twg_sine_rom #(
  parameter int ADDR_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [ADDR_BITS:0]             rd_addr,
  output logic [twg_pkg::AMP_W-1:0]      rd_data
);
  import twg_pkg::*;

  localparam int DEPTH = (1 << ADDR_BITS) + 1;

  typedef logic [AMP_W-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t tbl;
    for (int i = 0; i < DEPTH; i++) begin
      tbl[i] = sine_entry(i, ADDR_BITS);
    end
    return tbl;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [AMP_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r <= SINE_ROM[rd_addr];
    end
  end

  assign rd_data = data_r;

endmodule

[hw/rtl/tone_waveform_generator_unit.sv]
// top level of the tone generator: phase accumulator, sine lookup and gain pipeline
//
// Direct digital synthesis tone source. Every accepted input word (one tick,
// with a restart flag) yields exactly one output word: a signed 16-bit sample
// and a flag marking the last sample of the configured tone length. Throughput
// is one word per clock while out_ready is high. A word passes two register
// stages, the registered sine rom read and then the output register behind
// the gain multiplier, before out_valid rises. The output register lets a new
// input word enter while a finished sample still waits for out_ready.
// Registers on the APB-style port (byte
// addresses): 0x0 phase_step, 0x4 volume_gain (q1.15, values above 32768 act
// as full scale), 0x8 wave_mode (0 sine, 1 square), 0xC length_samples (a
// length of zero, or one beyond the sample counter, never flags a last sample
// and the counter wraps freely). Write configuration only while no word is in
// flight. The sine table holds a quarter wave of 2^TABLE_ADDR_BITS+1 entries;
// the other quadrants come from mirroring the address and negating.
module tone_waveform_generator_unit #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int COUNT_BITS      = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_restart,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [twg_pkg::SAMPLE_W-1:0]    out_sample_value,
  output logic                                   out_last_sample,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [twg_pkg::ADDR_W-1:0]             paddr,
  input  logic [twg_pkg::DATA_W-1:0]             pwdata,
  output logic [twg_pkg::DATA_W-1:0]             prdata,
  output logic                                   pready
);
  import twg_pkg::*;

  localparam int STEP_WIDE = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
  localparam int CMP_W     = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
  localparam int ROM_A_W   = TABLE_ADDR_BITS + 1;
  localparam int PROD_W    = AMP_W + GAIN_W;

  // configuration registers
  logic [STEP_W-1:0] phase_step_r;
  logic [GAIN_W-1:0] volume_gain_r;
  logic [MODE_W-1:0] wave_mode_r;
  logic [LEN_W-1:0]  length_samples_r;

  logic                       cfg_wr;
  logic [REG_SEL_W-1:0]       reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[ADDR_W-1:ADDR_W-REG_SEL_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r     <= '0;
      volume_gain_r    <= GAIN_FULL;
      wave_mode_r      <= MODE_SINE;
      length_samples_r <= LEN_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_PHASE_STEP: phase_step_r     <= pwdata[STEP_W-1:0];
        REG_VOLUME:     volume_gain_r    <= pwdata[GAIN_W-1:0];
        REG_WAVE_MODE:  wave_mode_r      <= pwdata[MODE_W-1:0];
        REG_LENGTH:     length_samples_r <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    case (reg_sel)
      REG_PHASE_STEP: prdata = DATA_W'(phase_step_r);
      REG_VOLUME:     prdata = DATA_W'(volume_gain_r);
      REG_WAVE_MODE:  prdata = DATA_W'(wave_mode_r);
      REG_LENGTH:     prdata = DATA_W'(length_samples_r);
      default:        prdata = '0;
    endcase
  end

  // pipeline flow control: stage 1 holds the rom read, stage 2 the output word
  logic s1_valid_r;
  logic s1_neg_r;
  logic s1_last_r;
  logic out_valid_r;
  logic s1_load;
  logic s2_load;
  logic accept;

  assign s2_load  = !out_valid_r || out_ready;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_ready = s1_load;
  assign accept   = in_valid && in_ready;

  // phase accumulator and sample counter, restart clears both first
  logic [PHASE_BITS-1:0] phase_acc_r;
  logic [PHASE_BITS-1:0] phase_acc_nxt;
  logic [COUNT_BITS-1:0] sample_index_r;
  logic [COUNT_BITS-1:0] sample_index_nxt;
  logic [PHASE_BITS-1:0] ph;
  logic [COUNT_BITS-1:0] idx;
  logic [STEP_WIDE-1:0]  step_wide;
  logic [CMP_W-1:0]      len_m1;
  logic                  is_last;
  logic                  neg;
  logic [1:0]            quad;
  logic [TABLE_ADDR_BITS-1:0] tab_addr;
  logic [ROM_A_W-1:0]    rom_addr;

  always_comb begin
    ph        = in_restart ? '0 : phase_acc_r;
    idx       = in_restart ? '0 : sample_index_r;
    step_wide = STEP_WIDE'(phase_step_r);
    len_m1    = CMP_W'(length_samples_r) - CMP_W'(1);
    // a zero length never matches; a length past the counter cannot match
    is_last   = (length_samples_r != '0) && (CMP_W'(idx) == len_m1);

    phase_acc_nxt    = ph + step_wide[PHASE_BITS-1:0];
    sample_index_nxt = is_last ? '0 : idx + COUNT_BITS'(1);

    // quadrant and table address from the top phase bits
    quad     = ph[PHASE_BITS-1 -: 2];
    tab_addr = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    // odd quadrants read the mirrored entry, N - a
    rom_addr = quad[0] ? (ROM_A_W'(1) << TABLE_ADDR_BITS) - ROM_A_W'(tab_addr)
                       : ROM_A_W'(tab_addr);
    // square: positive while the phase msb is set; sine: negative half wave
    neg = (wave_mode_r == MODE_SQUARE) ? !ph[PHASE_BITS-1] : quad[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r    <= '0;
      sample_index_r <= '0;
    end else if (accept) begin
      phase_acc_r    <= phase_acc_nxt;
      sample_index_r <= sample_index_nxt;
    end
  end

  // stage 1: sine lookup
  logic [AMP_W-1:0] rom_q;

  twg_sine_rom #(
    .ADDR_BITS (TABLE_ADDR_BITS)
  ) u_sine_rom (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rom_addr),
    .rd_data (rom_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_neg_r  <= neg;
      s1_last_r <= is_last;
    end
  end

  // stage 2: gain multiply, truncate magnitude, then apply sign
  logic [AMP_W-1:0]    mag;
  logic [GAIN_W-1:0]   gain;
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] scaled;
  logic [SAMPLE_W-1:0] sample_nxt;
  logic [SAMPLE_W-1:0] sample_r;
  logic                last_r;

  always_comb begin
    mag        = (wave_mode_r == MODE_SQUARE) ? FULL_AMP : rom_q;
    gain       = (volume_gain_r > GAIN_FULL) ? GAIN_FULL : volume_gain_r;
    prod       = PROD_W'(mag) * PROD_W'(gain);
    scaled     = prod[15 +: SAMPLE_W];
    sample_nxt = s1_neg_r ? (SAMPLE_W'(0) - scaled) : scaled;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      sample_r <= sample_nxt;
      last_r   <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = signed'(sample_r);
  assign out_last_sample  = last_r;

endmodule
